FILE: rtl/amr_pkg.sv
// Shared types and constants for the alpha-map run-length decoder.
// Used by every module of the block; no dependencies.
package amr_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DECODE_MODE = 2'd0;
    localparam logic [1:0] CFG_FIX_EDGES   = 2'd1;

    // Decode modes. Both codes with bit 1 set select run-length decoding.
    localparam logic [1:0] MODE_PACKED  = 2'd0;
    localparam logic [1:0] MODE_PLAIN   = 2'd1;
    localparam logic [1:0] MODE_RLE     = 2'd2;
    localparam logic [1:0] MODE_RLE_ALT = 2'd3;

    localparam logic [7:0] RLE_REPEAT_BIT = 8'h80;
    localparam int         QUEUE_DEPTH    = 4;

    typedef enum logic [1:0] {
        PH_COMMAND,
        PH_RUN_VALUE,
        PH_LITERAL
    } t_phase;

    // Work for the back end: a run of one value, a pair of values, or a tick.
    typedef enum logic [1:0] {
        OP_RUN,
        OP_PAIR,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [6:0] count;
        logic [7:0] v0;
        logic [7:0] v1;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [8:0]  word_index;
        logic [63:0] pixels;
        logic        last_word;
        logic        complete;
    } t_out_word;

endpackage

FILE: rtl/amr_ifs.sv
// Valid/ready channel interfaces of the alpha-map decoder: raw input,
// output words and configuration writes. No dependencies.
interface amr_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] raw_byte;

    modport source (output valid, output cmd, output raw_byte, input ready);
    modport sink   (input valid, input cmd, input raw_byte, output ready);
endinterface

interface amr_out_if;
    logic        valid;
    logic        ready;
    logic [8:0]  word_index;
    logic [63:0] pixels;
    logic        last_word;
    logic        complete;

    modport source (output valid, output word_index, output pixels, output last_word,
                    output complete, input ready);
    modport sink   (input valid, input word_index, input pixels, input last_word,
                    input complete, output ready);
endinterface

interface amr_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/alpha_map_rle_decoder.sv
// Top level of the alpha-map run-length decoder: configuration registers and
// the front end, work queue and back end. Depends on amr_pkg, amr_ifs and the amr_ modules.
//
// Usage. Raw requests arrive on i_in: cmd 0 carries a source byte, cmd 1 is a
// tick that ends the raw data and flushes one zero-padded word per tick. Words
// of eight pixels leave on o_out in row-major order; last_word marks the final
// word and complete is set there if the data alone filled the whole map.
// Configuration writes on i_cfg (index 0 decode mode, index 1 edge fix) are
// taken in any cycle out of reset and are meant to be made while the block is idle.
//
// Throughput. The front end takes one request a cycle while the four-entry
// queue has room. The back end places one pixel a cycle unless that pixel ends a
// word while o_out stalls; a request gives one pixel in plain mode, two in packed
// mode and n for a run of n; run-length command bytes give no back-end work, a
// tick emits a word. A word reaches o_out through the queue and the output register.
//
// Reset clears the parse state, the pixel count and the output valid flag and keeps
// i_in and i_cfg not ready; the edge-fix row buffer is always written before it is
// read. When o_out stalls, the finished word waits in the output register, the back
// end fills the next word, then the queue fills and i_in.ready drops.
module alpha_map_rle_decoder #(
    parameter int MAP_SIDE = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    amr_cfg_if.sink   i_cfg,
    amr_in_if.sink    i_in,
    amr_out_if.source o_out
);
    import amr_pkg::*;

    logic [1:0] r_decode_mode;
    logic       r_fix_edges;
    logic       push, pop;
    t_q_entry   push_entry, head;
    t_q_status  q_status;

    // Configuration writes are taken whenever reset is released; indexes beyond
    // the list are ignored.
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= MODE_PACKED;
            r_fix_edges   <= 1'b0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_DECODE_MODE) begin
                r_decode_mode <= i_cfg.data[1:0];
            end else if (i_cfg.index == CFG_FIX_EDGES) begin
                r_fix_edges <= i_cfg.data[0];
            end
        end
    end

    // The front end decodes each request under the mode current at that request.
    amr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_decode_mode),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    amr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // The back end owns the pixel count, word assembly and the edge fix.
    amr_back #(
        .MAP_SIDE (MAP_SIDE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fix_edges (r_fix_edges),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

FILE: rtl/amr_front.sv
// Front end: accepts input requests, tracks the run-length parse state and
// turns each request into a work entry for the queue. Depends on amr_pkg, amr_ifs.
module amr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_mode,
    amr_in_if.sink             i_in,
    input  amr_pkg::t_q_status i_q_status,
    output logic               o_push,
    output amr_pkg::t_q_entry  o_entry
);
    import amr_pkg::*;

    t_phase     r_phase, n_phase;
    logic [6:0] r_literal_left, n_literal_left;
    logic [6:0] r_run_length, n_run_length;
    logic       r_raw_ended, n_raw_ended;
    logic       accept;

    // No request is taken while reset is held.
    assign i_in.ready = i_rst_n && !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_COMMAND;
            r_literal_left <= '0;
            r_run_length   <= '0;
            r_raw_ended    <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_literal_left <= n_literal_left;
            r_run_length   <= n_run_length;
            r_raw_ended    <= n_raw_ended;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_literal_left = r_literal_left;
        n_run_length   = r_run_length;
        n_raw_ended    = r_raw_ended;
        o_push         = 1'b0;
        o_entry.op     = OP_RUN;
        o_entry.count  = 7'd1;
        o_entry.v0     = i_in.raw_byte;
        o_entry.v1     = i_in.raw_byte;
        if (accept) begin
            if (i_in.cmd) begin
                n_raw_ended = 1'b1;
                o_push      = 1'b1;
                o_entry.op  = OP_TICK;
            end else if (!r_raw_ended) begin
                unique case (i_mode) inside
                    MODE_RLE, MODE_RLE_ALT: begin
                        unique case (r_phase)
                            PH_RUN_VALUE: begin
                                // A zero-length run swallows its value byte.
                                o_push        = (r_run_length != 7'd0);
                                o_entry.count = r_run_length;
                                n_run_length  = '0;
                                n_phase       = PH_COMMAND;
                            end
                            PH_LITERAL: begin
                                o_push         = 1'b1;
                                n_literal_left = r_literal_left - 7'd1;
                                if (r_literal_left == 7'd1) begin
                                    n_phase = PH_COMMAND;
                                end
                            end
                            default: begin
                                if ((i_in.raw_byte & RLE_REPEAT_BIT) != 8'd0) begin
                                    n_run_length = i_in.raw_byte[6:0];
                                    n_phase      = PH_RUN_VALUE;
                                end else if (i_in.raw_byte[6:0] != 7'd0) begin
                                    n_literal_left = i_in.raw_byte[6:0];
                                    n_phase        = PH_LITERAL;
                                end
                            end
                        endcase
                    end
                    MODE_PLAIN: begin
                        o_push = 1'b1;
                    end
                    default: begin
                        // A nibble times 17 is the nibble written twice.
                        o_push     = 1'b1;
                        o_entry.op = OP_PAIR;
                        o_entry.v0 = {i_in.raw_byte[3:0], i_in.raw_byte[3:0]};
                        o_entry.v1 = {i_in.raw_byte[7:4], i_in.raw_byte[7:4]};
                    end
                endcase
            end
        end
    end

endmodule

FILE: rtl/amr_queue.sv
// Short work queue between the front and back ends of the decoder.
// Depends on amr_pkg.
module amr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  amr_pkg::t_q_entry  i_entry,
    input  logic               i_pop,
    output amr_pkg::t_q_entry  o_head,
    output amr_pkg::t_q_status o_status
);
    import amr_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_q_entry        r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [PW:0]     r_count;
    logic            do_push, do_pop;

    assign o_status.full  = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

FILE: rtl/amr_back.sv
// Back end: fills words one pixel a cycle unless o_out stalls, applies the edge fix
// and holds each finished word in the output register. Depends on amr_pkg, amr_ifs.
module amr_back #(
    parameter int MAP_SIDE = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fix_edges,
    input  amr_pkg::t_q_entry  i_head,
    input  amr_pkg::t_q_status i_q_status,
    output logic               o_pop,
    amr_out_if.source          o_out
);
    import amr_pkg::*;

    localparam int WPR       = MAP_SIDE / 8;
    localparam int NWORDS    = MAP_SIDE * MAP_SIDE / 8;
    localparam int IW        = $clog2(NWORDS);
    localparam int RW        = $clog2(MAP_SIDE);
    localparam int CW        = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int BUF_DEPTH = 1 << CW;

    logic [63:0]   r_asm, n_asm, asm_put;
    logic [2:0]    r_slot;
    logic [6:0]    r_sub;
    logic [IW-1:0] r_widx;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic          r_done;
    logic [63:0]   r_row_buf [BUF_DEPTH];
    t_out_word     r_out;
    logic          r_out_valid;

    logic          can_emit, emit, put, from_put, last_pixel, is_last;
    logic [7:0]    pix_val;
    logic [63:0]   emit_data, fixed_px;

    assign can_emit = !r_out_valid || o_out.ready;
    assign pix_val  = (i_head.op == OP_PAIR && r_sub[0]) ? i_head.v1 : i_head.v0;
    assign is_last  = (r_widx == IW'(NWORDS - 1));

    always_comb begin
        asm_put                 = r_asm;
        asm_put[r_slot*8 +: 8]  = pix_val;
    end

    always_comb begin
        o_pop      = 1'b0;
        emit       = 1'b0;
        put        = 1'b0;
        from_put   = 1'b0;
        emit_data  = r_asm;
        last_pixel = 1'b0;
        if (!i_q_status.empty) begin
            if (r_done) begin
                // The map is finished: everything left is dropped.
                o_pop = 1'b1;
            end else begin
                unique case (i_head.op)
                    OP_TICK: begin
                        if (can_emit) begin
                            emit  = 1'b1;
                            o_pop = 1'b1;
                        end
                    end
                    OP_RUN, OP_PAIR: begin
                        if (r_slot != 3'd7 || can_emit) begin
                            put        = 1'b1;
                            last_pixel = (i_head.op == OP_PAIR) ? r_sub[0]
                                       : (r_sub == i_head.count - 7'd1);
                            o_pop      = last_pixel;
                            if (r_slot == 3'd7) begin
                                emit      = 1'b1;
                                from_put  = 1'b1;
                                emit_data = asm_put;
                            end
                        end
                    end
                    default: begin
                        o_pop = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb begin
        fixed_px = emit_data;
        if (i_fix_edges) begin
            if (r_row == RW'(MAP_SIDE - 1)) begin
                fixed_px = r_row_buf[r_col];
            end
            if (r_col == CW'(WPR - 1)) begin
                fixed_px[63:56] = fixed_px[55:48];
            end
        end
    end

    always_comb begin
        n_asm = r_asm;
        if (emit) begin
            n_asm = '0;
        end else if (put) begin
            n_asm = asm_put;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asm       <= '0;
            r_slot      <= '0;
            r_sub       <= '0;
            r_widx      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_asm <= n_asm;
            if (o_pop) begin
                r_sub <= '0;
            end else if (put) begin
                r_sub <= r_sub + 7'd1;
            end
            if (emit) begin
                r_slot <= '0;
            end else if (put) begin
                r_slot <= r_slot + 3'd1;
            end
            if (emit) begin
                r_widx <= r_widx + 1'b1;
                if (r_col == CW'(WPR - 1)) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
                if (is_last) begin
                    r_done <= 1'b1;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.word_index <= 9'(r_widx);
            r_out.pixels     <= fixed_px;
            r_out.last_word  <= is_last;
            r_out.complete   <= is_last && from_put;
            if (r_row == RW'(MAP_SIDE - 2)) begin
                r_row_buf[r_col] <= emit_data;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.word_index = r_out.word_index;
    assign o_out.pixels     = r_out.pixels;
    assign o_out.last_word  = r_out.last_word;
    assign o_out.complete   = r_out.complete;

endmodule
